// ----- hdl/pida_pkg.sv -----
package pida_pkg;

    localparam int DATA_W  = 32;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int GROUP_W = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_READ   = 2'd3
    } t_req_type;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef logic signed [DATA_W-1:0] t_data;

    // Broadcast to every cell for one accepted request.
    typedef struct packed {
        logic ins;
        logic del;
        logic rd;
    } t_cell_ctl;

endpackage

// ----- hdl/pida_cell.sv -----
module pida_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                i_clk,
    input  pida_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]       i_pos,
    input  pida_pkg::t_data     i_value,
    input  pida_pkg::t_data     i_left,
    input  pida_pkg::t_data     i_right,
    output pida_pkg::t_data     o_data,
    output pida_pkg::t_data     o_hit
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    pida_pkg::t_data r_data;
    pida_pkg::t_data n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (MY_IDX == i_pos) begin
                n_data = i_value;
            end else if (MY_IDX > i_pos) begin
                n_data = i_left;
            end
        end else if (i_ctl.del) begin
            if (MY_IDX >= i_pos) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // Only the addressed cell drives a nonzero word onto the read tree.
    assign o_hit  = (i_ctl.rd && (MY_IDX == i_pos)) ? r_data : '0;

endmodule

// ----- hdl/pida_rdgrp.sv -----
module pida_rdgrp #(
    parameter int N = 8
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  pida_pkg::t_data i_hit [N],
    output pida_pkg::t_data o_data
);

    pida_pkg::t_data r_data;
    pida_pkg::t_data n_data;

    always_comb begin
        n_data = '0;
        for (int k = 0; k < N; k++) begin
            n_data = n_data | i_hit[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// ----- hdl/positional_insert_delete_array_core.sv -----
// Ordered array of signed 32-bit elements with insert, delete, read and clear.
// Request channel: i_valid/o_stall with i_req_type, i_position, i_value_in.
// Result channel: o_valid/i_stall with o_status, o_value_out, o_count_out.
// Each element lives in its own cell; on an insert the cells above the position
// load from their left neighbors, on a delete those at or above it from their
// right neighbors, all in the same cycle. The addressed element is picked out
// through a two-level OR tree with one register level, then registered at the output.
// Requests are taken every cycle; the sustained rate is one per cycle as long
// as the result side keeps up. When a result is held by i_stall, one more
// request is taken and then o_stall rises until the held result leaves.
// Synchronous reset empties the array (count zero) and drops any pending
// results; element storage is not cleared and is never read before written.
module positional_insert_delete_array_core #(
    parameter int CAPACITY = 64,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_req_type,
    input  logic [CW-1:0]         i_position,
    input  logic signed [31:0]    i_value_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_status,
    output logic signed [31:0]    o_value_out,
    output logic [CW-1:0]         o_count_out
);

    localparam int GS = pida_pkg::GROUP_W;
    localparam int NG = (CAPACITY + GS - 1) / GS;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    pida_pkg::t_status   n_status;
    pida_pkg::t_cell_ctl ctl;
    pida_pkg::t_req_type req;
    logic                accept;
    logic                out_free;

    logic                r_pend;
    pida_pkg::t_status   r_pend_status;
    logic [CW-1:0]       r_pend_count;

    logic                r_out_valid;
    pida_pkg::t_status   r_status;
    pida_pkg::t_data     r_value;
    logic [CW-1:0]       r_count_o;

    pida_pkg::t_data     cell_data [CAPACITY];
    pida_pkg::t_data     hit [NG*GS];
    pida_pkg::t_data     grp_data [NG];
    pida_pkg::t_data     rd_value;

    assign req      = pida_pkg::t_req_type'(i_req_type);
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = r_pend && !out_free;
    assign accept   = i_valid && !o_stall;

    always_comb begin
        n_status = pida_pkg::ST_OK;
        n_count  = r_count;
        ctl      = '0;
        case (req)
            pida_pkg::REQ_CLEAR: begin
                n_count = '0;
            end
            pida_pkg::REQ_INSERT: begin
                if (r_count >= CAP_C) begin
                    n_status = pida_pkg::ST_FULL;
                end else if (i_position > r_count) begin
                    n_status = pida_pkg::ST_BADPOS;
                end else begin
                    ctl.ins = accept;
                    n_count = r_count + 1'b1;
                end
            end
            pida_pkg::REQ_DELETE: begin
                if (r_count == '0) begin
                    n_status = pida_pkg::ST_EMPTY;
                end else if (i_position >= r_count) begin
                    n_status = pida_pkg::ST_BADPOS;
                end else begin
                    ctl.del = accept;
                    ctl.rd  = accept;
                    n_count = r_count - 1'b1;
                end
            end
            pida_pkg::REQ_READ: begin
                if (r_count == '0) begin
                    n_status = pida_pkg::ST_EMPTY;
                end else if (i_position >= r_count) begin
                    n_status = pida_pkg::ST_BADPOS;
                end else begin
                    ctl.rd = accept;
                end
            end
            default: begin
                n_status = pida_pkg::ST_OK;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            pida_pkg::t_data left_w;
            pida_pkg::t_data right_w;
            if (gi == 0) begin : g_first
                assign left_w = i_value_in;
            end else begin : g_mid_l
                assign left_w = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_w = cell_data[gi];
            end else begin : g_mid_r
                assign right_w = cell_data[gi+1];
            end
            pida_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_pos   (i_position),
                .i_value (i_value_in),
                .i_left  (left_w),
                .i_right (right_w),
                .o_data  (cell_data[gi]),
                .o_hit   (hit[gi])
            );
        end
        for (gi = CAPACITY; gi < NG*GS; gi++) begin : g_pad
            assign hit[gi] = '0;
        end
        for (gi = 0; gi < NG; gi++) begin : g_grp
            pida_rdgrp #(
                .N (GS)
            ) u_rdgrp (
                .i_clk  (i_clk),
                .i_en   (accept),
                .i_hit  (hit[gi*GS +: GS]),
                .o_data (grp_data[gi])
            );
        end
    endgenerate

    always_comb begin
        rd_value = '0;
        for (int k = 0; k < NG; k++) begin
            rd_value = rd_value | grp_data[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_pend  <= 1'b1;
            end else if (out_free) begin
                r_pend  <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_status <= n_status;
            r_pend_count  <= n_count;
        end
        if (r_pend && out_free) begin
            r_status  <= r_pend_status;
            r_value   <= rd_value;
            r_count_o <= r_pend_count;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_value_out = r_value;
    assign o_count_out = r_count_o;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("element count above capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (req == pida_pkg::REQ_CLEAR) |=> r_count == '0)
        else $error("clear did not empty the array");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ins |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the count");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != pida_pkg::ST_OK) |-> o_value_out == '0)
        else $error("failed request returned a nonzero value");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int CAPACITY    = 64;
    localparam int CW          = $clog2(CAPACITY + 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 30;

    typedef struct {
        pida_pkg::t_status status;
        pida_pkg::t_data   value;
        logic [CW-1:0]     count;
    } t_outcome;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_valid     = 1'b0;
    logic [1:0]      i_req_type  = pida_pkg::REQ_CLEAR;
    logic [CW-1:0]   i_position  = '0;
    pida_pkg::t_data i_value_in  = '0;
    logic            i_stall     = 1'b0;
    logic            o_stall;
    logic            o_valid;
    logic [1:0]      o_status;
    pida_pkg::t_data o_value_out;
    logic [CW-1:0]   o_count_out;

    // Array contents and live count as the block should hold them.
    pida_pkg::t_data shadow_elems [CAPACITY];
    int              shadow_count = 0;
    int              peak_count   = 0;
    t_outcome        pending_results [$];

    bit idle_on        = 1'b1;
    int errors         = 0;
    int cycles         = 0;
    int results_seen   = 0;
    int req_tally [4]  = '{default: 0};
    int stat_tally [4] = '{default: 0};

    positional_insert_delete_array_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req_type(i_req_type),
        .i_position(i_position),
        .i_value_in(i_value_in),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_value_out(o_value_out),
        .o_count_out(o_count_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending.",
                     cycles, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // The result side holds off in random bursts while idling is enabled.
    always begin
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
            i_stall <= 1'b0;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("MISMATCH at cycle %0d: %s", cycles, msg);
    endtask

    // Applies one request to the shadow array and returns what the block must answer.
    function automatic t_outcome apply_request(pida_pkg::t_req_type kind,
                                               logic [CW-1:0] pos,
                                               pida_pkg::t_data val);
        t_outcome r;
        r.status = pida_pkg::ST_OK;
        r.value  = '0;
        case (kind)
            pida_pkg::REQ_CLEAR: begin
                shadow_count = 0;
            end
            pida_pkg::REQ_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = pida_pkg::ST_FULL;
                end else if (int'(pos) > shadow_count) begin
                    r.status = pida_pkg::ST_BADPOS;
                end else begin
                    for (int i = shadow_count; i > int'(pos); i--)
                        shadow_elems[i] = shadow_elems[i-1];
                    shadow_elems[pos] = val;
                    shadow_count++;
                end
            end
            pida_pkg::REQ_DELETE: begin
                if (shadow_count == 0) begin
                    r.status = pida_pkg::ST_EMPTY;
                end else if (int'(pos) >= shadow_count) begin
                    r.status = pida_pkg::ST_BADPOS;
                end else begin
                    r.value = shadow_elems[pos];
                    for (int i = int'(pos); i + 1 < shadow_count; i++)
                        shadow_elems[i] = shadow_elems[i+1];
                    shadow_count--;
                end
            end
            default: begin
                if (shadow_count == 0)
                    r.status = pida_pkg::ST_EMPTY;
                else if (int'(pos) >= shadow_count)
                    r.status = pida_pkg::ST_BADPOS;
                else
                    r.value = shadow_elems[pos];
            end
        endcase
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        r.count = shadow_count[CW-1:0];
        return r;
    endfunction

    // Results are checked before the request taken at the same edge is predicted,
    // since no result can belong to a request accepted in that very cycle.
    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result arrived with no request outstanding");
                end else begin
                    want = pending_results.pop_front();
                    stat_tally[want.status]++;
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, want.status));
                    if (o_value_out !== want.value)
                        report_mismatch($sformatf("value_out %h, expected %h",
                                                  o_value_out, want.value));
                    if (o_count_out !== want.count)
                        report_mismatch($sformatf("count_out %0d, expected %0d",
                                                  o_count_out, want.count));
                end
            end
            if (i_valid && !o_stall) begin
                req_tally[i_req_type]++;
                pending_results.push_back(
                    apply_request(pida_pkg::t_req_type'(i_req_type),
                                  i_position, i_value_in));
            end
        end
    end

    // Entered and left at a falling edge; valid stays high for a following request.
    task automatic send_request(input pida_pkg::t_req_type kind,
                                input logic [CW-1:0] pos,
                                input pida_pkg::t_data val);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= kind;
        i_position <= pos;
        i_value_in <= val;
        do
            @(posedge i_clk);
        while (o_stall);
        @(negedge i_clk);
    endtask

    function automatic pida_pkg::t_data pick_value();
        case ($urandom_range(0, 11))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return '1;
            default: return pida_pkg::t_data'($urandom);
        endcase
    endfunction

    // Mostly well-formed positions, with some anywhere in the 7-bit field.
    task automatic send_random(input int clear_pct, input int insert_pct);
        int                  pick;
        pida_pkg::t_req_type kind;
        logic [CW-1:0]       pos;
        pick = $urandom_range(0, 99);
        if (pick < clear_pct)
            kind = pida_pkg::REQ_CLEAR;
        else if (pick < clear_pct + insert_pct)
            kind = pida_pkg::REQ_INSERT;
        else if (pick % 2 == 0)
            kind = pida_pkg::REQ_DELETE;
        else
            kind = pida_pkg::REQ_READ;
        if ($urandom_range(0, 99) < 15)
            pos = CW'($urandom_range(0, (1 << CW) - 1));
        else if (kind == pida_pkg::REQ_INSERT)
            pos = CW'($urandom_range(0, shadow_count));
        else if (shadow_count > 0)
            pos = CW'($urandom_range(0, shadow_count - 1));
        else
            pos = '0;
        send_request(kind, pos, pick_value());
    endtask

    task automatic test_empty_and_edges();
        send_request(pida_pkg::REQ_READ,   7'd0,   '0);
        send_request(pida_pkg::REQ_DELETE, 7'd127, '0);
        send_request(pida_pkg::REQ_INSERT, 7'd1,   32'sd5);
        send_request(pida_pkg::REQ_INSERT, 7'd127, 32'sd6);
        send_request(pida_pkg::REQ_CLEAR,  7'd0,   '0);
        send_request(pida_pkg::REQ_INSERT, 7'd0,   32'sh8000_0000);
        send_request(pida_pkg::REQ_INSERT, 7'd1,   32'sh7fff_ffff);
        send_request(pida_pkg::REQ_INSERT, 7'd0,   '1);
        send_request(pida_pkg::REQ_INSERT, 7'd1,   '0);
        send_request(pida_pkg::REQ_INSERT, 7'd4,   32'sh5555_5555);
        send_request(pida_pkg::REQ_INSERT, 7'd6,   32'sh1234_5678);
        send_request(pida_pkg::REQ_READ,   7'd0,   '0);
        send_request(pida_pkg::REQ_READ,   7'd4,   '0);
        send_request(pida_pkg::REQ_READ,   7'd5,   '0);
        send_request(pida_pkg::REQ_READ,   7'd127, '0);
        send_request(pida_pkg::REQ_DELETE, 7'd2,   '0);
        send_request(pida_pkg::REQ_DELETE, 7'd0,   '0);
        send_request(pida_pkg::REQ_DELETE, 7'd2,   '0);
        send_request(pida_pkg::REQ_DELETE, 7'd5,   '0);
        send_request(pida_pkg::REQ_CLEAR,  7'd0,   '0);
        send_request(pida_pkg::REQ_READ,   7'd0,   '0);
        send_request(pida_pkg::REQ_INSERT, 7'd0,   32'shaaaa_aaaa);
        send_request(pida_pkg::REQ_READ,   7'd0,   '0);
    endtask

    // A full array must refuse inserts before it looks at the position.
    task automatic test_full_array();
        send_request(pida_pkg::REQ_CLEAR, 7'd0, '0);
        while (shadow_count < CAPACITY)
            send_request(pida_pkg::REQ_INSERT, CW'($urandom_range(0, shadow_count)),
                         pick_value());
        send_request(pida_pkg::REQ_INSERT, 7'd127, pick_value());
        send_request(pida_pkg::REQ_INSERT, 7'd0,   pick_value());
        send_request(pida_pkg::REQ_INSERT, CW'(CAPACITY), pick_value());
        send_request(pida_pkg::REQ_READ,   CW'(CAPACITY - 1), '0);
        send_request(pida_pkg::REQ_READ,   CW'(CAPACITY), '0);
        send_request(pida_pkg::REQ_DELETE, CW'(CAPACITY), '0);
        send_request(pida_pkg::REQ_DELETE, CW'(CAPACITY - 1), '0);
        send_request(pida_pkg::REQ_INSERT, CW'(CAPACITY - 1), pick_value());
        while (shadow_count > 0)
            send_request(pida_pkg::REQ_DELETE,
                         CW'($urandom_range(0, shadow_count - 1)), '0);
        send_request(pida_pkg::REQ_DELETE, 7'd0, '0);
    endtask

    // Alternating growth and shrink phases walk the count from empty to full and back.
    task automatic test_random_traffic();
        for (int round = 0; round < 4; round++) begin
            repeat (150) send_random(0, 75);
            repeat (150) send_random(0, 15);
            repeat (100) send_random(3, 45);
        end
    endtask

    task automatic test_quiet_tail();
        idle_on = 1'b0;
        repeat (100) send_random(0, 70);
        repeat (100) send_random(2, 40);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_and_edges();
        test_full_array();
        test_random_traffic();
        test_quiet_tail();

        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d clears, %0d inserts, %0d deletes and %0d reads; %s %0d of %0d.",
                 req_tally[pida_pkg::REQ_CLEAR], req_tally[pida_pkg::REQ_INSERT],
                 req_tally[pida_pkg::REQ_DELETE], req_tally[pida_pkg::REQ_READ],
                 "count peaked at", peak_count, CAPACITY);
        $display("Checked %0d results: %0d ok, %0d bad position, %0d full, %0d empty; %s",
                 results_seen, stat_tally[pida_pkg::ST_OK],
                 stat_tally[pida_pkg::ST_BADPOS], stat_tally[pida_pkg::ST_FULL],
                 stat_tally[pida_pkg::ST_EMPTY], $sformatf("%0d mismatches.", errors));
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- positional_insert_delete_array_core.f -----
hdl/pida_pkg.sv
hdl/pida_cell.sv
hdl/pida_rdgrp.sv
hdl/positional_insert_delete_array_core.sv
tb/tb.sv
